// ----- sv/ntab_pkg.sv -----
// ntab_pkg: shared types, codes and constants of the neighbor table block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package ntab_pkg;

  localparam int NODE_COUNT_DEF = 32;
  localparam int COORD_DIMS_DEF = 3;
  localparam int COORD_BITS_DEF = 24;
  localparam int MIN_PAYLOAD    = 3;
  localparam int MAX_OUT        = 32;
  localparam int QDEPTH         = 2;

  localparam logic [15:0] STALE_RST   = 16'd50;
  localparam logic [15:0] MIN_GAP_RST = 16'd1;
  localparam logic [15:0] MAX_GAP_RST = 16'd20;
  localparam logic [51:0] THR_RST     = 52'd65536;
  localparam logic        SEND_EN_RST = 1'b1;

  localparam logic [2:0] CFG_STALE   = 3'd0;
  localparam logic [2:0] CFG_MIN_GAP = 3'd1;
  localparam logic [2:0] CFG_MAX_GAP = 3'd2;
  localparam logic [2:0] CFG_THR     = 3'd3;
  localparam logic [2:0] CFG_SEND_EN = 3'd4;

  typedef enum logic [1:0] {
    OP_RECV = 2'd0,
    OP_SEND = 2'd1,
    OP_LIST = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_RECV  = 2'd0,
    KIND_SEND  = 2'd1,
    KIND_NBR   = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    RS_STORED       = 3'd0,
    RS_WRONG_TYPE   = 3'd1,
    RS_SHORT        = 3'd2,
    RS_ID_MISMATCH  = 3'd3,
    RS_DECODE_FAIL  = 3'd4,
    RS_OUT_OF_RANGE = 3'd5
  } rstat_t;

  typedef enum logic [2:0] {
    SR_TOO_SOON  = 3'd0,
    SR_LOW_MOVE  = 3'd1,
    SR_FIRST     = 3'd2,
    SR_MOVED     = 3'd3,
    SR_HEARTBEAT = 3'd4,
    SR_SKIPPED   = 3'd5
  } reason_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQ,
    B_ACC,
    B_CMP,
    B_DEC,
    B_LRD,
    B_LCHK,
    B_LEND
  } bstate_t;

  typedef struct packed {
    op_t              op;
    rstat_t           status;
    logic [7:0]       id;
    logic             pos_valid;
    logic [2:0][31:0] pos;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- sv/ntab_front.sv -----
// ntab_front: accepts input beats, runs the receive checks, normalizes coordinates
// depends on ntab_pkg; feeds ntab_fifo
`timescale 1ns / 1ps
`default_nettype none

module ntab_front
  import ntab_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic        in_is_neighbor_type,
  input  wire logic [7:0]  in_payload_length,
  input  wire logic [7:0]  in_header_source,
  input  wire logic [7:0]  in_payload_id,
  input  wire logic        in_decode_ok,
  input  wire logic        in_position_valid,
  input  wire logic [23:0] in_pos_x,
  input  wire logic [23:0] in_pos_y,
  input  wire logic [23:0] in_pos_z,
  input  wire q_stat_t     q_stat,
  output logic             q_push,
  output item_t            q_item
);

  localparam int SH = 32 - COORD_BITS;

  logic [2:0][31:0] raw;
  logic [2:0][31:0] crd;
  rstat_t           stat;

  assign raw[0] = {{8{in_pos_x[23]}}, in_pos_x};
  assign raw[1] = {{8{in_pos_y[23]}}, in_pos_y};
  assign raw[2] = {{8{in_pos_z[23]}}, in_pos_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      crd[i] = 32'($signed(raw[i] << SH) >>> SH);
    end
  end

  always_comb begin
    if (!in_is_neighbor_type) begin
      stat = RS_WRONG_TYPE;
    end else if (in_payload_length < 8'(MIN_PAYLOAD)) begin
      stat = RS_SHORT;
    end else if (in_header_source != in_payload_id) begin
      stat = RS_ID_MISMATCH;
    end else if (!in_decode_ok) begin
      stat = RS_DECODE_FAIL;
    end else if ({1'b0, in_payload_id} >= 9'(NODE_COUNT)) begin
      stat = RS_OUT_OF_RANGE;
    end else begin
      stat = RS_STORED;
    end
  end

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full && (in_action != 2'd3);

  always_comb begin
    q_item           = '0;
    q_item.op        = op_t'(in_action);
    q_item.status    = stat;
    q_item.id        = in_payload_id;
    q_item.pos_valid = in_position_valid;
    q_item.pos       = crd;
  end

endmodule

`default_nettype wire

// ----- sv/ntab_fifo.sv -----
// ntab_fifo: short queue of classified items between front and back
// depends on ntab_pkg
`timescale 1ns / 1ps
`default_nettype none

module ntab_fifo
  import ntab_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output q_stat_t    stat
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wp_r;
  logic [QAW-1:0] rp_r;
  logic [QCW-1:0] cnt_r;

  assign stat.full  = (cnt_r == QCW'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == QAW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == QAW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/ntab_back.sv -----
// ntab_back: neighbor table, tick, beacon gate, listing walk and result register
// depends on ntab_pkg; pops items from ntab_fifo
`timescale 1ns / 1ps
`default_nettype none

module ntab_back
  import ntab_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int COORD_DIMS = COORD_DIMS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [51:0] cfg_data,
  input  wire item_t       q_item,
  input  wire q_stat_t     q_stat,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [2:0]       out_receive_status,
  output logic             out_send_now,
  output logic [2:0]       out_send_reason,
  output logic [7:0]       out_nbr_id,
  output logic [31:0]      out_neighbor_age,
  output logic             out_last_item
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int FW = $clog2(MAX_OUT + 1);

  // configuration
  logic [15:0] stale_r, min_gap_r, max_gap_r;
  logic [51:0] thr_r;
  logic        send_en_r;

  // control and beacon state
  bstate_t          state_r, state_nxt;
  logic [31:0]      tick_r, tick_nxt;
  logic             has_sent_r, has_sent_nxt;
  logic [31:0]      lst_tick_r, lst_tick_nxt;
  logic [2:0][31:0] lst_pos_r, lst_pos_nxt;
  logic [2:0][31:0] cur_pos_r, cur_pos_nxt;
  logic [31:0]      now_r, now_nxt;
  reason_t          reason_r, reason_nxt;
  logic [1:0]       d_r, d_nxt;
  logic [63:0]      sq_r, sq_nxt;
  logic [63:0]      sum_r, sum_nxt;

  // table and listing walk
  logic [NODE_COUNT-1:0] vld_r, vld_nxt;
  logic [31:0]           seen_mem_r [NODE_COUNT];
  logic [31:0]           rd_data_r;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [FW-1:0]         found_r, found_nxt;
  logic                  pend_vld_r, pend_vld_nxt;
  logic [IW-1:0]         pend_id_r, pend_id_nxt;
  logic [31:0]           pend_age_r, pend_age_nxt;

  // result register
  logic       out_vld_r;
  kind_t      out_kind_r;
  rstat_t     out_stat_r;
  logic       out_now_r;
  reason_t    out_reason_r;
  logic [7:0] out_id_r;
  logic [31:0] out_age_r;
  logic       out_last_r;

  logic       ld;
  kind_t      o_kind;
  rstat_t     o_stat;
  logic       o_now;
  reason_t    o_reason;
  logic [7:0] o_id;
  logic [31:0] o_age;
  logic       o_last;

  // shared decode
  logic        can_load;
  logic        q_vld;
  logic        send_skip;
  logic        need_move;
  logic [31:0] since;
  logic [31:0] age;
  logic        live;
  logic        take;
  logic        hold;
  logic        idx_last;
  logic        d_last;
  logic        send_go;
  logic [32:0] diff;
  logic [32:0] mag;
  logic [63:0] sq_c;
  logic [64:0] acc;

  assign can_load  = !out_vld_r || !out_stall;
  assign q_vld     = !q_stat.empty;
  assign send_skip = !send_en_r || !q_item.pos_valid;
  assign since     = tick_r - lst_tick_r;
  assign need_move = has_sent_r && (since >= {16'b0, min_gap_r}) &&
                     (since < {16'b0, max_gap_r});
  assign age       = tick_r - rd_data_r;
  assign live      = vld_r[idx_r] && (age <= {16'b0, stale_r});
  assign take      = live && (found_r < FW'(MAX_OUT));
  assign hold      = take && pend_vld_r && !can_load;
  assign idx_last  = (idx_r == IW'(NODE_COUNT - 1));
  assign d_last    = (d_r == 2'(COORD_DIMS - 1));
  assign send_go   = (reason_r == SR_FIRST) || (reason_r == SR_MOVED) ||
                     (reason_r == SR_HEARTBEAT);

  assign diff = {cur_pos_r[d_r][31], cur_pos_r[d_r]} - {lst_pos_r[d_r][31], lst_pos_r[d_r]};
  assign mag  = diff[32] ? (33'd0 - diff) : diff;
  assign sq_c = mag[32] ? '1 : (64'(mag[31:0]) * 64'(mag[31:0]));
  assign acc  = {1'b0, sum_r} + {1'b0, sq_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_vld) begin
          case (q_item.op)
            OP_SEND: begin
              if (!send_skip) begin
                state_nxt = need_move ? B_SQ : B_DEC;
              end
            end
            OP_LIST: state_nxt = B_LRD;
            default: state_nxt = B_IDLE;
          endcase
        end
      end
      B_SQ:  state_nxt = B_ACC;
      B_ACC: state_nxt = d_last ? B_CMP : B_SQ;
      B_CMP: state_nxt = B_DEC;
      B_DEC: begin
        if (can_load) begin
          state_nxt = B_IDLE;
        end
      end
      B_LRD: state_nxt = B_LCHK;
      B_LCHK: begin
        if (!hold) begin
          state_nxt = idx_last ? B_LEND : B_LRD;
        end
      end
      B_LEND: begin
        if (can_load) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop        = 1'b0;
    ld           = 1'b0;
    o_kind       = KIND_RECV;
    o_stat       = RS_STORED;
    o_now        = 1'b0;
    o_reason     = SR_TOO_SOON;
    o_id         = '0;
    o_age        = '0;
    o_last       = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = q_item.id[IW-1:0];
    tick_nxt     = tick_r;
    has_sent_nxt = has_sent_r;
    lst_tick_nxt = lst_tick_r;
    lst_pos_nxt  = lst_pos_r;
    cur_pos_nxt  = cur_pos_r;
    now_nxt      = now_r;
    reason_nxt   = reason_r;
    d_nxt        = d_r;
    sq_nxt       = sq_r;
    sum_nxt      = sum_r;
    vld_nxt      = vld_r;
    idx_nxt      = idx_r;
    found_nxt    = found_r;
    pend_vld_nxt = pend_vld_r;
    pend_id_nxt  = pend_id_r;
    pend_age_nxt = pend_age_r;
    case (state_r)
      B_IDLE: begin
        if (q_vld) begin
          case (q_item.op)
            OP_RECV: begin
              if (can_load) begin
                q_pop  = 1'b1;
                ld     = 1'b1;
                o_kind = KIND_RECV;
                o_stat = q_item.status;
                o_last = 1'b1;
                if (q_item.status == RS_STORED) begin
                  wr_en            = 1'b1;
                  vld_nxt[wr_addr] = 1'b1;
                end
              end
            end
            OP_SEND: begin
              if (send_skip) begin
                if (can_load) begin
                  q_pop    = 1'b1;
                  ld       = 1'b1;
                  o_kind   = KIND_SEND;
                  o_reason = SR_SKIPPED;
                  o_last   = 1'b1;
                end
              end else begin
                q_pop       = 1'b1;
                cur_pos_nxt = q_item.pos;
                now_nxt     = tick_r;
                tick_nxt    = tick_r + 32'd1;
                d_nxt       = '0;
                sum_nxt     = '0;
                if (!has_sent_r) begin
                  reason_nxt = SR_FIRST;
                end else if (since < {16'b0, min_gap_r}) begin
                  reason_nxt = SR_TOO_SOON;
                end else if (since < {16'b0, max_gap_r}) begin
                  reason_nxt = SR_LOW_MOVE;
                end else begin
                  reason_nxt = SR_HEARTBEAT;
                end
              end
            end
            OP_LIST: begin
              q_pop        = 1'b1;
              idx_nxt      = '0;
              found_nxt    = '0;
              pend_vld_nxt = 1'b0;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      B_SQ: sq_nxt = sq_c;
      B_ACC: begin
        sum_nxt = acc[64] ? '1 : acc[63:0];
        if (!d_last) begin
          d_nxt = d_r + 2'd1;
        end
      end
      B_CMP: reason_nxt = (sum_r < {12'b0, thr_r}) ? SR_LOW_MOVE : SR_MOVED;
      B_DEC: begin
        if (can_load) begin
          ld       = 1'b1;
          o_kind   = KIND_SEND;
          o_now    = send_go;
          o_reason = reason_r;
          o_last   = 1'b1;
          if (send_go) begin
            has_sent_nxt = 1'b1;
            lst_tick_nxt = now_r;
            lst_pos_nxt  = cur_pos_r;
          end
        end
      end
      B_LRD: ;
      B_LCHK: begin
        if (!hold) begin
          vld_nxt[idx_r] = live;
          if (!idx_last) begin
            idx_nxt = idx_r + 1'b1;
          end
          if (take) begin
            found_nxt    = found_r + 1'b1;
            pend_vld_nxt = 1'b1;
            pend_id_nxt  = idx_r;
            pend_age_nxt = age;
            if (pend_vld_r) begin
              ld     = 1'b1;
              o_kind = KIND_NBR;
              o_id   = 8'(pend_id_r);
              o_age  = pend_age_r;
            end
          end
        end
      end
      B_LEND: begin
        if (can_load) begin
          ld     = 1'b1;
          o_last = 1'b1;
          if (pend_vld_r) begin
            o_kind = KIND_NBR;
            o_id   = 8'(pend_id_r);
            o_age  = pend_age_r;
          end else begin
            o_kind = KIND_EMPTY;
          end
        end
      end
      default: ;
    endcase
  end

  // last-seen store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      seen_mem_r[wr_addr] <= tick_r;
    end
    rd_data_r <= seen_mem_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r    <= STALE_RST;
      min_gap_r  <= MIN_GAP_RST;
      max_gap_r  <= MAX_GAP_RST;
      thr_r      <= THR_RST;
      send_en_r  <= SEND_EN_RST;
      state_r    <= B_IDLE;
      tick_r     <= '0;
      has_sent_r <= 1'b0;
      vld_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_STALE:   stale_r   <= cfg_data[15:0];
          CFG_MIN_GAP: min_gap_r <= cfg_data[15:0];
          CFG_MAX_GAP: max_gap_r <= cfg_data[15:0];
          CFG_THR:     thr_r     <= cfg_data;
          CFG_SEND_EN: send_en_r <= cfg_data[0];
          default: ;
        endcase
      end
      state_r    <= state_nxt;
      tick_r     <= tick_nxt;
      has_sent_r <= has_sent_nxt;
      vld_r      <= vld_nxt;
      if (ld) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lst_tick_r <= lst_tick_nxt;
    lst_pos_r  <= lst_pos_nxt;
    cur_pos_r  <= cur_pos_nxt;
    now_r      <= now_nxt;
    reason_r   <= reason_nxt;
    d_r        <= d_nxt;
    sq_r       <= sq_nxt;
    sum_r      <= sum_nxt;
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    pend_vld_r <= pend_vld_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_age_r <= pend_age_nxt;
    if (ld) begin
      out_kind_r   <= o_kind;
      out_stat_r   <= o_stat;
      out_now_r    <= o_now;
      out_reason_r <= o_reason;
      out_id_r     <= o_id;
      out_age_r    <= o_age;
      out_last_r   <= o_last;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_result_kind    = out_kind_r;
  assign out_receive_status = out_stat_r;
  assign out_send_now       = out_now_r;
  assign out_send_reason    = out_reason_r;
  assign out_nbr_id         = out_id_r;
  assign out_neighbor_age   = out_age_r;
  assign out_last_item      = out_last_r;

endmodule

`default_nettype wire

// ----- sv/neighbor_table_aging_beacon_gate_unit.sv -----
// neighbor_table_aging_beacon_gate_unit: top level of the neighbor table block
// depends on ntab_pkg, ntab_front, ntab_fifo, ntab_back
`timescale 1ns / 1ps
`default_nettype none

// Neighbor table with aging and a hello-beacon gate. Input beats are checked
// and queued (two entries) by the front; the back executes one item at a time.
// After the queue, a receive or a skipped send is answered from idle, a send
// decided on timing alone goes on to the decision state, and a send that
// needs the movement test runs square and accumulate once per axis, then
// compare, since one shared 32x32 multiplier squares one axis per pass. A
// listing reads the last-seen memory one entry at a time (registered read,
// then age check and eviction) and may stall. At most 32 entries are listed.
module neighbor_table_aging_beacon_gate_unit
  import ntab_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int COORD_DIMS = COORD_DIMS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [51:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic        in_is_neighbor_type,
  input  wire logic [7:0]  in_payload_length,
  input  wire logic [7:0]  in_header_source,
  input  wire logic [7:0]  in_payload_id,
  input  wire logic        in_decode_ok,
  input  wire logic        in_position_valid,
  input  wire logic [23:0] in_pos_x,
  input  wire logic [23:0] in_pos_y,
  input  wire logic [23:0] in_pos_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [2:0]       out_receive_status,
  output logic             out_send_now,
  output logic [2:0]       out_send_reason,
  output logic [7:0]       out_nbr_id,
  output logic [31:0]      out_neighbor_age,
  output logic             out_last_item
);

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  item_t   q_in;
  item_t   q_head;

  ntab_front #(
    .NODE_COUNT(NODE_COUNT),
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_is_neighbor_type (in_is_neighbor_type),
    .in_payload_length   (in_payload_length),
    .in_header_source    (in_header_source),
    .in_payload_id       (in_payload_id),
    .in_decode_ok        (in_decode_ok),
    .in_position_valid   (in_position_valid),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_pos_z            (in_pos_z),
    .q_stat              (q_stat),
    .q_push              (q_push),
    .q_item              (q_in)
  );

  ntab_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  ntab_back #(
    .NODE_COUNT(NODE_COUNT),
    .COORD_DIMS(COORD_DIMS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_data           (cfg_data),
    .q_item             (q_head),
    .q_stat             (q_stat),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_receive_status (out_receive_status),
    .out_send_now       (out_send_now),
    .out_send_reason    (out_send_reason),
    .out_nbr_id         (out_nbr_id),
    .out_neighbor_age   (out_neighbor_age),
    .out_last_item      (out_last_item)
  );

`ifndef SYNTH
  a_q_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty together");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_RECV || out_result_kind == KIND_SEND ||
                  out_result_kind == KIND_EMPTY) |-> out_last_item)
    else $error("single-result beat without last marker");

  a_send_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_SEND && out_send_now |->
      (out_send_reason == SR_FIRST || out_send_reason == SR_MOVED ||
       out_send_reason == SR_HEARTBEAT))
    else $error("beacon sent with a no-send reason");
`endif

endmodule

`default_nettype wire
